[src/msp_pkg.sv]
`default_nettype none

package msp_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_SET     = 2'd1,
    KIND_TRIGGER = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         voice;
    logic [13:0]        address;
    logic signed [15:0] sample;
    logic [14:0]        length;
    logic [15:0]        step;
    logic               loop;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] mix;
    logic [3:0]         active_count;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_VOICE,
    ST_SAMPLE_A,
    ST_SAMPLE_B,
    ST_MUL_B,
    ST_ACC,
    ST_ABS,
    ST_DIV_LOAD,
    ST_DIV_WAIT
  } state_t;

  // Step after reset: one sample per tick.
  localparam logic [15:0] STEP_RESET = 16'd16384;

  localparam logic signed [15:0] MIX_MAX = 16'sh7FFF;
  localparam logic signed [15:0] MIX_MIN = 16'sh8000;

endpackage

`default_nettype wire

[src/msp_ram.sv]
`default_nettype none

module msp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/msp_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module msp_div #(
  parameter int NW = 21,
  parameter int DW = 4,
  localparam int CNTW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  logic            running;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [DW:0]     trial;
  logic            ge;

  assign trial = {rem, quotient[NW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNTW'(NW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      rem      <= ge ? DW'(trial - {1'b0, dvs}) : DW'(trial);
      quotient <= {quotient[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[src/multi_voice_sample_player.sv]
`default_nettype none

// Channel   Direction  Ports                 Handshake
// command   in         cmd (cmd_t)           taken when start is high and busy is low
// result    out        result (result_t)     valid for the one cycle that done is high
//
// A load word is written to the sample store in the cycle it is taken; busy stays low.
// Set and trigger words read, modify and write back the voice entry while busy is high.
// A tick walks the voices one after another through the voice table: a silent or
// ending voice takes only the voice state, a playing one also two sample reads and
// two products, then the absolute-value and divide-load states follow, and when any
// voice was active a divide. Only the tick gives a result, strobed in the first cycle
// that busy is low; the next word can be taken in that same cycle. The receiver cannot
// stall, so done is never held.
// Reset clears the voice table's valid bits at once, so the block takes words from
// the first cycle after reset.
module multi_voice_sample_player #(
  parameter int VOICES      = 8,
  parameter int STORE_DEPTH = 16384,
  parameter int FRAC_BITS   = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  msp_pkg::cmd_t     cmd,
  output logic              done,
  output msp_pkg::result_t  result
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int LW  = $clog2(STORE_DEPTH + 1);
  localparam int IW  = AW + 2;
  localparam int PW  = AW + FRAC_BITS + 1;
  localparam int SAW = (VOICES * STORE_DEPTH > 1) ? $clog2(VOICES * STORE_DEPTH) : 1;
  localparam int CW  = $clog2(VOICES + 1);
  localparam int PRW = FRAC_BITS + 18;
  localparam int SW  = FRAC_BITS + CW + 17;
  localparam int NW  = CW + 17;

  typedef struct packed {
    logic           active;
    logic           lp;
    logic [15:0]    step;
    logic [LW-1:0]  length;
    logic [PW-1:0]  position;
  } voice_t;

  localparam int EW = $bits(voice_t);

  msp_pkg::state_t state, state_next;

  // Voice table entry is valid once written; otherwise it reads as reset.
  logic [VOICES-1:0] vvalid;
  logic              rd_valid;

  logic            v_we;
  logic [VW-1:0]   v_waddr, v_raddr;
  voice_t          v_wdata;
  logic [EW-1:0]   v_rdata;

  logic            s_we;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [15:0]     s_rdata;

  msp_pkg::cmd_t   cmd_q;
  logic [VW-1:0]   vidx;
  logic [CW-1:0]   count;
  logic signed [SW-1:0] acc;
  logic [SW-1:0]   mag;
  logic            neg;
  logic [FRAC_BITS-1:0] frac;
  logic [SAW-1:0]  rd_addr_q;
  logic signed [15:0]   samp_a, samp_b;
  logic signed [PRW-1:0] prod;

  voice_t          cur, wb_entry, upd_entry, reset_entry;
  logic [PW-1:0]   pos_sum;
  logic [AW:0]     idx_full;
  logic            in_range;
  logic            last_voice;
  logic            voice_ok, addr_ok;
  logic [LW-1:0]   len_sat;
  logic [SAW-1:0]  play_addr, load_addr;

  logic signed [15:0]     mul_x;
  logic [FRAC_BITS:0]     mul_w, unity;
  logic signed [PRW-1:0]  mul_out;

  logic            div_start, div_done;
  logic [NW-1:0]   div_quotient;
  logic [SW-1:0]   rounded;
  logic signed [15:0] mix_sat;

  assign busy = (state != msp_pkg::ST_IDLE);

  // ---- voice entry decode ----
  assign reset_entry = '{active: 1'b0, lp: 1'b0, step: msp_pkg::STEP_RESET,
                         length: '0, position: '0};
  assign cur = rd_valid ? voice_t'(v_rdata) : reset_entry;

  // Advance the position and test the next index against the length.
  assign pos_sum  = cur.position + PW'(cur.step);
  assign idx_full = pos_sum[PW-1:FRAC_BITS];
  assign in_range = (({1'b0, idx_full} + 1'b1) < IW'(cur.length));
  assign last_voice = (vidx == VW'(VOICES - 1));

  // Past the end: wrap to zero when looping, else drop out.
  always_comb begin
    wb_entry = cur;
    wb_entry.position = in_range ? pos_sum : '0;
    wb_entry.active   = in_range | cur.lp;
  end

  assign voice_ok = (5'(cmd.voice) < 5'(VOICES));
  assign addr_ok  = (21'(cmd.address) < 21'(STORE_DEPTH));
  assign len_sat  = (21'(cmd_q.length) > 21'(STORE_DEPTH)) ? LW'(STORE_DEPTH)
                                                          : LW'(cmd_q.length);

  // Set keeps position and activity; trigger keeps the settings.
  always_comb begin
    upd_entry = cur;
    if (cmd_q.kind == msp_pkg::KIND_SET) begin
      upd_entry.length = len_sat;
      upd_entry.step   = cmd_q.step;
      upd_entry.lp     = cmd_q.loop;
    end else begin
      upd_entry.active   = 1'b1;
      upd_entry.position = '0;
    end
  end

  assign play_addr = SAW'(vidx) * SAW'(STORE_DEPTH) + SAW'(idx_full[AW-1:0]);
  assign load_addr = SAW'(VW'(cmd.voice)) * SAW'(STORE_DEPTH) + SAW'(cmd.address);

  // ---- shared multiplier: s[i] * (1 - f), then s[i+1] * f ----
  assign unity   = {1'b1, {FRAC_BITS{1'b0}}};
  assign mul_x   = (state == msp_pkg::ST_MUL_B) ? samp_b : samp_a;
  assign mul_w   = (state == msp_pkg::ST_MUL_B) ? {1'b0, frac} : (unity - {1'b0, frac});
  assign mul_out = mul_x * $signed({1'b0, mul_w});

  // ---- averaging: round half away from zero on the magnitude ----
  assign rounded = mag + (SW'(count) << (FRAC_BITS - 1));

  always_comb begin
    if (neg) begin
      mix_sat = (div_quotient > NW'(32768)) ? msp_pkg::MIX_MIN
                                            : 16'(16'd0 - div_quotient[15:0]);
    end else begin
      mix_sat = (div_quotient > NW'(32767)) ? msp_pkg::MIX_MAX
                                            : $signed(div_quotient[15:0]);
    end
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      msp_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd.kind)
            msp_pkg::KIND_SET, msp_pkg::KIND_TRIGGER: begin
              if (voice_ok) state_next = msp_pkg::ST_UPDATE;
            end
            msp_pkg::KIND_TICK: state_next = msp_pkg::ST_VOICE;
            default: ;
          endcase
        end
      end
      msp_pkg::ST_UPDATE: state_next = msp_pkg::ST_IDLE;
      msp_pkg::ST_VOICE: begin
        if (cur.active && in_range) begin
          state_next = msp_pkg::ST_SAMPLE_A;
        end else if (last_voice) begin
          state_next = msp_pkg::ST_ABS;
        end
      end
      msp_pkg::ST_SAMPLE_A: state_next = msp_pkg::ST_SAMPLE_B;
      msp_pkg::ST_SAMPLE_B: state_next = msp_pkg::ST_MUL_B;
      msp_pkg::ST_MUL_B:    state_next = msp_pkg::ST_ACC;
      msp_pkg::ST_ACC:      state_next = last_voice ? msp_pkg::ST_ABS : msp_pkg::ST_VOICE;
      msp_pkg::ST_ABS:      state_next = msp_pkg::ST_DIV_LOAD;
      msp_pkg::ST_DIV_LOAD: begin
        state_next = (count == '0) ? msp_pkg::ST_IDLE : msp_pkg::ST_DIV_WAIT;
      end
      msp_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = msp_pkg::ST_IDLE;
      end
      default: state_next = msp_pkg::ST_IDLE;
    endcase
  end

  // ---- memory and divider controls ----
  always_comb begin
    v_we      = 1'b0;
    v_waddr   = vidx;
    v_wdata   = wb_entry;
    v_raddr   = vidx + 1'b1;
    s_we      = 1'b0;
    s_waddr   = load_addr;
    s_raddr   = play_addr;
    div_start = 1'b0;
    case (state)
      msp_pkg::ST_IDLE: begin
        v_raddr = (cmd.kind == msp_pkg::KIND_TICK) ? '0 : VW'(cmd.voice);
        s_we    = start && (cmd.kind == msp_pkg::KIND_LOAD) && voice_ok && addr_ok;
      end
      msp_pkg::ST_UPDATE: begin
        v_we    = 1'b1;
        v_waddr = VW'(cmd_q.voice);
        v_wdata = upd_entry;
      end
      msp_pkg::ST_VOICE: begin
        v_we = cur.active;
      end
      msp_pkg::ST_SAMPLE_A: begin
        s_raddr = rd_addr_q + 1'b1;
      end
      msp_pkg::ST_DIV_LOAD: begin
        div_start = (count != '0);
      end
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= msp_pkg::ST_IDLE;
      vvalid <= '0;
      done   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (v_we) vvalid[v_waddr] <= 1'b1;
      if (state == msp_pkg::ST_DIV_LOAD && count == '0) done <= 1'b1;
      if (state == msp_pkg::ST_DIV_WAIT && div_done) done <= 1'b1;
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    rd_valid <= vvalid[v_raddr];
    case (state)
      msp_pkg::ST_IDLE: begin
        cmd_q <= cmd;
        vidx  <= '0;
        count <= '0;
        acc   <= '0;
      end
      msp_pkg::ST_VOICE: begin
        if (cur.active) count <= count + 1'b1;
        frac      <= pos_sum[FRAC_BITS-1:0];
        rd_addr_q <= play_addr;
        if (!(cur.active && in_range)) vidx <= vidx + 1'b1;
      end
      msp_pkg::ST_SAMPLE_A: begin
        samp_a <= $signed(s_rdata);
      end
      msp_pkg::ST_SAMPLE_B: begin
        samp_b <= $signed(s_rdata);
        prod   <= mul_out;
      end
      msp_pkg::ST_MUL_B: begin
        acc  <= acc + {{(SW - PRW){prod[PRW-1]}}, prod};
        prod <= mul_out;
      end
      msp_pkg::ST_ACC: begin
        acc  <= acc + {{(SW - PRW){prod[PRW-1]}}, prod};
        vidx <= vidx + 1'b1;
      end
      msp_pkg::ST_ABS: begin
        neg <= acc[SW-1];
        mag <= acc[SW-1] ? $unsigned(-acc) : $unsigned(acc);
      end
      msp_pkg::ST_DIV_LOAD: begin
        if (count == '0) result <= '{mix: '0, active_count: '0};
      end
      msp_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          result.mix          <= mix_sat;
          result.active_count <= 4'(count);
        end
      end
      default: ;
    endcase
  end

  msp_ram #(
    .WIDTH (EW),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  msp_ram #(
    .WIDTH (16),
    .DEPTH (VOICES * STORE_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (cmd.sample),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  msp_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rounded[FRAC_BITS +: NW]),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire
